[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files of the radix digit converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define SIRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition is followed by another one in the next cycle.
`define SIRD_ASSERT_NEXT(lbl, cond, nxt_cond, msg) \
  `SIRD_ASSERT(lbl, (cond) |=> (nxt_cond), msg)

`endif

[rtl/sird_pkg.sv]
// Types, constants and helper functions of the radix digit converter.
package sird_pkg;

  // Alphabet limits
  localparam int MAX_RADIX   = 16;
  localparam int ALPHA_BYTES = 16;
  localparam int ALPHA_W     = ALPHA_BYTES * 8;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Magnitude word and division steps (one byte of quotient per step)
  localparam int MAG_W = 32;
  localparam logic [1:0] STEP_LAST = 2'd3;

  // Character codes
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_LOW   = 8'd33;
  localparam logic [7:0] CHAR_HIGH  = 8'd126;
  localparam logic [4:0] RADIX_MIN  = 5'd2;

  // Register reset values
  localparam logic [4:0]  RADIX_RST      = 5'd10;
  localparam logic [63:0] ALPHA_LOW_RST  = 64'h3736353433323130;
  localparam logic [63:0] ALPHA_HIGH_RST = 64'h0000000000003938;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RADIX      = 2'd0,
    CFG_ALPHA_LOW  = 2'd1,
    CFG_ALPHA_HIGH = 2'd2
  } cfg_idx_t;

  // One queued number: sign and magnitude
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } item_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_LOAD
  } back_state_t;

  // Pick alphabet character k
  function automatic logic [7:0] alpha_char(input logic [ALPHA_W-1:0] alpha,
                                            input logic [3:0] k);
    return alpha[{k, 3'b000} +: 8];
  endfunction

endpackage

[rtl/signed_int_to_radix_digits.sv]
// Top level of the signed integer to radix digit converter.
//
// Usage: numbers enter on in_valid/in_ready/in_number; characters leave on
// out_valid/out_ready/out_char/out_last, most significant digit first, with
// a leading '-' for negative numbers and out_last on the final character.
// The cfg_we/cfg_index/cfg_wdata port writes radix, alphabet_low and
// alphabet_high; write them only while no number is in flight. A number
// that meets an invalid alphabet is taken and dropped with no output.
// A front end checks the alphabet and queues sign and magnitude in a
// two-entry queue; the back end divides by the radix one quotient byte per
// cycle, then sends the sign and reads each digit character through the
// registered read port of the store.
// Reset: synchronous, active low; restores radix 10 and alphabet
// "0123456789" and empties the queue and the output register.
// A stalled receiver holds the output register; the back end waits and
// the queue fills, after which in_ready drops.
module signed_int_to_radix_digits
  import sird_pkg::*;
#(
  parameter int DIGIT_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_char,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);

  logic [4:0]         radix_r;
  logic [63:0]        alpha_low_r;
  logic [63:0]        alpha_high_r;
  logic [ALPHA_W-1:0] alpha;

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  item_t q_in;
  item_t q_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r      <= RADIX_RST;
      alpha_low_r  <= ALPHA_LOW_RST;
      alpha_high_r <= ALPHA_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIX:      radix_r      <= cfg_wdata[4:0];
        CFG_ALPHA_LOW:  alpha_low_r  <= cfg_wdata;
        CFG_ALPHA_HIGH: alpha_high_r <= cfg_wdata;
        default:        radix_r      <= radix_r;
      endcase
    end
  end

  assign alpha = {alpha_high_r, alpha_low_r};

  sird_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_number (in_number),
    .radix     (radix_r),
    .alpha     (alpha),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  sird_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .empty     (q_empty)
  );

  sird_back #(
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .radix     (radix_r),
    .alpha     (alpha),
    .q_empty   (q_empty),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

[rtl/sird_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sird_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/sird_front.sv]
// Front end: accepts numbers, checks the alphabet and forms sign and magnitude.
module sird_front
  import sird_pkg::*;
(
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_number,
  input  logic [4:0]         radix,
  input  logic [ALPHA_W-1:0] alpha,
  input  logic               q_full,
  output logic               q_push,
  output item_t              q_item
);

  logic        alpha_bad;
  logic [31:0] raw;

  // Flag a radix out of range, a forbidden character or a repeated one
  always_comb begin
    logic [7:0] c_a;
    alpha_bad = (radix < RADIX_MIN) || (radix > 5'(MAX_RADIX));
    for (int a = 0; a < ALPHA_BYTES; a++) begin
      c_a = alpha[a*8 +: 8];
      if (radix > 5'(a)) begin
        if (c_a < CHAR_LOW || c_a > CHAR_HIGH || c_a == CHAR_PLUS || c_a == CHAR_MINUS) begin
          alpha_bad = 1'b1;
        end
        for (int b = a + 1; b < ALPHA_BYTES; b++) begin
          if (radix > 5'(b) && alpha[b*8 +: 8] == c_a) begin
            alpha_bad = 1'b1;
          end
        end
      end
    end
  end

  // Take a number whenever the queue has room; drop it on a bad alphabet
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && !alpha_bad;

  // Two's complement magnitude, the most negative value maps to 2^31
  assign raw        = unsigned'(in_number);
  assign q_item.neg = raw[31];
  assign q_item.mag = raw[31] ? (32'd0 - raw) : raw;

endmodule

[rtl/sird_fifo.sv]
// Short queue of numbers between the front and back ends.
`include "assert_macros.svh"
module sird_fifo
  import sird_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = entry_r[rd_ptr_r];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `SIRD_ASSERT(a_no_underflow, pop |-> (count_r != '0), "queue popped while empty")
  `SIRD_ASSERT(a_count_bound, count_r <= CW'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

[rtl/sird_back.sv]
// Back end: divides the magnitude into digits, then sends sign and characters.
`include "assert_macros.svh"
module sird_back
  import sird_pkg::*;
#(
  parameter int DIGIT_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [4:0]         radix,
  input  logic [ALPHA_W-1:0] alpha,
  input  logic               q_empty,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_char,
  output logic               out_last
);

  localparam int AW = $clog2(DIGIT_DEPTH);

  back_state_t      state_r, state_nxt;
  logic [MAG_W-1:0] work_r, work_nxt;
  logic [3:0]       rem_r, rem_nxt;
  logic [1:0]       step_r;
  logic [AW-1:0]    pos_r;
  logic             neg_r;
  logic [7:0]       qbyte;
  logic             div_done;

  logic             out_valid_r;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_free;
  logic             out_load;

  logic             ram_we;
  logic             ram_re;
  logic [3:0]       ram_rdata;

  // Digit store: least significant digit at address zero
  sird_ram #(
    .WIDTH (4),
    .DEPTH (DIGIT_DEPTH)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (rem_nxt),
    .re    (ram_re),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  // One quotient byte per cycle by restoring long division
  always_comb begin
    logic [4:0] r;
    logic [4:0] t;
    r     = {1'b0, rem_r};
    qbyte = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {r[3:0], work_r[24 + i]};
      if (t >= radix) begin
        r        = t - radix;
        qbyte[i] = 1'b1;
      end else begin
        r = t;
      end
    end
    rem_nxt  = r[3:0];
    work_nxt = {work_r[23:0], qbyte};
  end

  assign div_done = (work_nxt == '0) || (pos_r == AW'(DIGIT_DEPTH - 1));
  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (step_r == STEP_LAST && div_done) state_nxt = neg_r ? ST_SIGN : ST_READ;
      end
      ST_SIGN: begin
        if (out_free) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) state_nxt = (pos_r == '0) ? ST_IDLE : ST_READ;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    out_load     = 1'b0;
    out_char_nxt = CHAR_MINUS;
    out_last_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        q_pop = !q_empty;
      end
      ST_DIV: begin
        ram_we = (step_r == STEP_LAST);
      end
      ST_SIGN: begin
        out_load = out_free;
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_LOAD: begin
        out_load     = out_free;
        out_char_nxt = alpha_char(alpha, ram_rdata);
        out_last_nxt = (pos_r == '0);
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Division and digit position datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_r <= q_item.mag;
      neg_r  <= q_item.neg;
      rem_r  <= '0;
      step_r <= '0;
      pos_r  <= '0;
    end else if (state_r == ST_DIV) begin
      work_r <= work_nxt;
      step_r <= step_r + 1'b1;
      if (step_r == STEP_LAST && !div_done) begin
        pos_r <= pos_r + 1'b1;
        rem_r <= '0;
      end else begin
        rem_r <= rem_nxt;
      end
    end else if (state_r == ST_LOAD && out_load && pos_r != '0) begin
      pos_r <= pos_r - 1'b1;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  `SIRD_ASSERT(a_rem_below_radix, (state_r == ST_DIV) |-> ({1'b0, rem_r} < radix), "rem too big")
  `SIRD_ASSERT_NEXT(a_last_idle, out_load && out_last_nxt, state_r == ST_IDLE, "busy after last")

endmodule
